// ===== hw/rtl/empa_pkg.sv =====
// Package for the EM path abundance block: word types, state encoding, codes
// and widths. No dependencies.
`timescale 1ns / 1ps

package empa_pkg;

    // Default sizes for the top-level parameters
    localparam int MAX_PATHS_DEF         = 32;
    localparam int MAX_HITS_DEF          = 4096;
    localparam int MAX_HITS_PER_READ_DEF = 64;

    // Fixed field and datapath widths
    localparam int PID_W   = 6;
    localparam int CNT_W   = 7;
    localparam int W16     = 16;
    localparam int ABN_W   = 32;
    localparam int SHARE_W = 33;
    localparam int DEN_W   = 40;
    localparam int DIVD_W  = 49;
    localparam int DIVS_W  = 40;
    localparam int PROD_W  = 48;
    localparam int CFG_AW  = 2;

    localparam logic [ABN_W-1:0] ONE_Q16    = 32'h0001_0000;
    localparam logic [W16-1:0]   WEIGHT_ONE = 16'h8000;

    // Action codes
    localparam logic [1:0] ACT_LEN = 2'd0;
    localparam logic [1:0] ACT_HIT = 2'd1;
    localparam logic [1:0] ACT_RUN = 2'd2;

    // Register indexes
    localparam logic [CFG_AW-1:0] REG_EPSILON  = 2'd0;
    localparam logic [CFG_AW-1:0] REG_MAX_ITER = 2'd1;
    localparam logic [CFG_AW-1:0] REG_PCOUNT   = 2'd2;

    typedef struct packed {
        logic [1:0]       action;
        logic [PID_W-1:0] path_id;
        logic [W16-1:0]   path_length;
        logic [W16-1:0]   hit_count;
        logic             end_of_read;
    } t_in_word;

    typedef struct packed {
        logic [PID_W-1:0] out_path;
        logic [ABN_W-1:0] abundance;
        logic             converged;
        logic [W16-1:0]   iterations_used;
        logic             last;
    } t_out_word;

    typedef enum logic [4:0] {
        S_IDLE, S_LEN, S_LDIV, S_INIT, S_ITER, S_RHIT, S_RABN, S_RMUL, S_RACC,
        S_DIST, S_DBUF, S_DDIV, S_UPD, S_UMUL, S_UCMP, S_UEND, S_ERD, S_EOUT
    } t_state;

endpackage

// ===== hw/rtl/empa_div.sv =====
// Restoring divider for the EM path abundance block, one quotient bit a cycle.
// Depends on empa_pkg.
`timescale 1ns / 1ps

module empa_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [empa_pkg::DIVD_W-1:0]  i_dividend,
    input  logic [empa_pkg::DIVS_W-1:0]  i_divisor,
    output logic                         o_done,
    output logic [empa_pkg::DIVD_W-1:0]  o_quotient
);
    import empa_pkg::*;

    localparam int STEP_W = $clog2(DIVD_W);

    logic              r_busy, r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIVS_W-1:0] r_rem, r_div;
    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W:0]   trial, diff;
    logic              ge;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial = {r_rem, r_quo[DIVD_W-1]};
        ge    = trial >= {1'b0, r_div};
        diff  = trial - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(DIVD_W - 1);
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
                r_quo <= {r_quo[DIVD_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== hw/rtl/em_path_abundance.sv =====
// EM path abundance estimator: top level with sequencer, stores and shared
// multiplier. Depends on empa_pkg and empa_div.
// Loading: a length word is written directly; a hit word is stored at once on a zero
// length, else after its weight is divided. Run: a setup pass over MAX_PATHS entries,
// then per iteration a pass over the hit entries, per read a divide for each entry when
// the share sum is nonzero (the divider does one bit a cycle) and an update per path.
// One word at a time. Reset sets control and config defaults; no memory clearing pass.
`timescale 1ns / 1ps

module em_path_abundance #(
    parameter int MAX_PATHS         = empa_pkg::MAX_PATHS_DEF,
    parameter int MAX_HITS          = empa_pkg::MAX_HITS_DEF,
    parameter int MAX_HITS_PER_READ = empa_pkg::MAX_HITS_PER_READ_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  empa_pkg::t_in_word         i_in,
    output logic                       o_valid,
    input  logic                       i_stall,
    output empa_pkg::t_out_word        o_out,
    input  logic                       i_cfg_we,
    input  logic [empa_pkg::CFG_AW-1:0] i_cfg_idx,
    input  logic [15:0]                i_cfg_data
);
    import empa_pkg::*;

    localparam int PATH_AW = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
    localparam int HIT_AW  = $clog2(MAX_HITS);
    localparam int FILL_W  = $clog2(MAX_HITS + 1);
    localparam int NPR_W   = $clog2(MAX_HITS_PER_READ + 1);
    localparam int BUF_AW  = (MAX_HITS_PER_READ > 1) ? $clog2(MAX_HITS_PER_READ) : 1;
    localparam int HIT_W   = 1 + PID_W + W16;
    localparam int BUF_W   = PID_W + SHARE_W;

    // Stores
    logic [W16-1:0]   len_mem [MAX_PATHS];
    logic [HIT_W-1:0] hit_mem [MAX_HITS];
    logic [ABN_W-1:0] abn_mem [MAX_PATHS];
    logic [ABN_W-1:0] acc_mem [MAX_PATHS];
    logic [BUF_W-1:0] buf_mem [MAX_HITS_PER_READ];

    // Configuration
    logic [W16-1:0]   r_eps, r_maxit;
    logic [CNT_W-1:0] r_pcount;

    // Sequencer registers
    t_state r_state, n_state;
    logic [FILL_W-1:0] r_fill, n_fill, r_e, n_e;
    logic [NPR_W-1:0]  r_n, n_n, r_j, n_j;
    logic [CNT_W-1:0]  r_np, n_np, r_p, n_p;
    logic [W16-1:0]    r_iters, n_iters;
    logic              r_conv, n_conv, r_cv, n_cv;
    logic [DEN_W-1:0]  r_den, n_den;
    logic [PID_W-1:0]  r_id, n_id, r_hpath, n_hpath, r_bpath, n_bpath;
    logic [W16-1:0]    r_hits, n_hits, r_hw, n_hw;
    logic              r_eor, n_eor, r_hmark, n_hmark;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [ABN_W-1:0]  r_old, n_old, r_new, n_new;

    // Registered memory read data
    logic [W16-1:0]   r_len_rd;
    logic [HIT_W-1:0] r_hit_rd;
    logic [ABN_W-1:0] r_abn_rd, r_acc_rd;
    logic [BUF_W-1:0] r_buf_rd;

    // Memory ports
    logic              len_we, hit_we, abn_we, acc_we, buf_we;
    logic [HIT_W-1:0]  hit_wdata;
    logic [PATH_AW-1:0] abn_waddr, acc_waddr, abn_raddr, acc_raddr;
    logic [ABN_W-1:0]  abn_wdata, acc_wdata;
    logic [HIT_AW-1:0] hit_raddr;
    logic [BUF_AW-1:0] buf_raddr;
    logic [BUF_W-1:0]  buf_wdata;

    // Shared units
    logic              div_start, div_done;
    logic [DIVD_W-1:0] div_dividend, div_quo;
    logic [DIVS_W-1:0] div_divisor;
    logic [ABN_W-1:0]  mul_a;
    logic [W16-1:0]    mul_b;
    logic [PROD_W-1:0] mul_p;

    // Helpers
    logic              in_acc, out_acc, plen_zero, hit_ok, bnd, unconv;
    logic [W16-1:0]    plen, wsat;
    logic [SHARE_W-1:0] share;
    logic [ABN_W:0]    acc_sum;
    logic [ABN_W-1:0]  delta;
    logic [NPR_W-1:0]  n_inc;
    logic [FILL_W-1:0] e_inc;
    logic [CNT_W-1:0]  np_clamp;

    empa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_EOUT);

    // Present the current path's result
    always_comb begin
        o_out.out_path        = r_p[PID_W-1:0];
        o_out.abundance       = r_abn_rd;
        o_out.converged       = r_conv;
        o_out.iterations_used = r_iters;
        o_out.last            = (r_p + 1'b1 == r_np);
    end

    // Datapath helpers
    always_comb begin
        plen      = ({1'b0, r_id} < CNT_W'(MAX_PATHS)) ? r_len_rd : '0;
        plen_zero = (plen == '0);
        wsat      = (div_quo > DIVD_W'(WEIGHT_ONE)) ? WEIGHT_ONE : div_quo[W16-1:0];
        hit_ok    = ({1'b0, r_hpath} < r_np);
        share     = hit_ok ? r_prod[PROD_W-1:15] : '0;
        acc_sum   = {1'b0, r_acc_rd} + (ABN_W+1)'(div_quo[16:0]);
        n_inc     = r_n + 1'b1;
        e_inc     = r_e + 1'b1;
        bnd       = r_hmark || (n_inc == NPR_W'(MAX_HITS_PER_READ)) || (e_inc >= r_fill);
        delta     = (r_new > r_old) ? (r_new - r_old) : (r_old - r_new);
        unconv    = (r_old == '0) ? (r_new != '0)
                                  : ({delta, 16'b0} > r_prod);
        if (r_pcount == '0)
            np_clamp = CNT_W'(1);
        else if (r_pcount > CNT_W'(MAX_PATHS))
            np_clamp = CNT_W'(MAX_PATHS);
        else
            np_clamp = r_pcount;
    end

    // Sequencer: next state, memory strobes, unit operands
    always_comb begin
        n_state = r_state; n_fill = r_fill; n_e = r_e; n_n = r_n; n_j = r_j;
        n_np = r_np; n_p = r_p; n_iters = r_iters; n_conv = r_conv; n_cv = r_cv;
        n_den = r_den; n_id = r_id; n_hpath = r_hpath; n_bpath = r_bpath;
        n_hits = r_hits; n_hw = r_hw; n_eor = r_eor; n_hmark = r_hmark;
        n_prod = r_prod; n_old = r_old; n_new = r_new;

        len_we = 1'b0; hit_we = 1'b0; abn_we = 1'b0; acc_we = 1'b0; buf_we = 1'b0;
        hit_wdata = {r_eor, r_id, WEIGHT_ONE};
        abn_waddr = r_p[PATH_AW-1:0]; acc_waddr = r_p[PATH_AW-1:0];
        abn_wdata = ONE_Q16; acc_wdata = '0;
        abn_raddr = r_p[PATH_AW-1:0]; acc_raddr = r_bpath[PATH_AW-1:0];
        hit_raddr = r_e[HIT_AW-1:0];
        buf_raddr = r_j[BUF_AW-1:0];
        buf_wdata = {r_hpath, share};
        div_start = 1'b0;
        div_dividend = DIVD_W'({r_hits, 15'b0});
        div_divisor  = DIVS_W'(plen);
        mul_a = r_abn_rd; mul_b = r_hw;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in.action)
                        ACT_LEN: len_we = ({1'b0, i_in.path_id} < CNT_W'(MAX_PATHS));
                        ACT_HIT: begin
                            if (r_fill < FILL_W'(MAX_HITS)) begin
                                n_id    = i_in.path_id;
                                n_hits  = i_in.hit_count;
                                n_eor   = i_in.end_of_read;
                                n_state = S_LEN;
                            end
                        end
                        ACT_RUN: begin
                            n_np    = np_clamp;
                            n_p     = '0;
                            n_state = S_INIT;
                        end
                        default: ;
                    endcase
                end
            end
            // Weight: store directly on zero length, else divide
            S_LEN: begin
                if (plen_zero) begin
                    hit_we    = 1'b1;
                    hit_wdata = {r_eor, r_id, (r_hits != '0) ? WEIGHT_ONE : 16'h0000};
                    n_fill    = r_fill + 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_LDIV;
                end
            end
            S_LDIV: begin
                if (div_done) begin
                    hit_we    = 1'b1;
                    hit_wdata = {r_eor, r_id, wsat};
                    n_fill    = r_fill + 1'b1;
                    n_state   = S_IDLE;
                end
            end
            // Set every abundance to one and clear the accumulators
            S_INIT: begin
                abn_we = 1'b1;
                acc_we = 1'b1;
                n_p    = r_p + 1'b1;
                if (r_p == CNT_W'(MAX_PATHS - 1)) begin
                    n_iters = '0;
                    n_conv  = 1'b0;
                    n_p     = '0;
                    n_state = (r_maxit == '0) ? S_ERD : S_ITER;
                end
            end
            S_ITER: begin
                n_iters = r_iters + 1'b1;
                n_e     = '0;
                n_n     = '0;
                n_den   = '0;
                n_p     = '0;
                n_cv    = 1'b1;
                n_state = (r_fill == '0) ? S_UPD : S_RHIT;
            end
            S_RHIT: n_state = S_RABN;
            S_RABN: begin
                n_hmark   = r_hit_rd[HIT_W-1];
                n_hpath   = r_hit_rd[W16 +: PID_W];
                n_hw      = r_hit_rd[W16-1:0];
                abn_raddr = r_hit_rd[W16 +: PATH_AW];
                n_state   = S_RMUL;
            end
            S_RMUL: begin
                abn_raddr = r_hpath[PATH_AW-1:0];
                n_prod    = mul_p;
                n_state   = S_RACC;
            end
            // Buffer the share and add it to the read's sum
            S_RACC: begin
                buf_we  = 1'b1;
                n_den   = r_den + DEN_W'(share);
                n_n     = n_inc;
                n_e     = e_inc;
                n_j     = '0;
                n_state = bnd ? S_DIST : S_RHIT;
            end
            S_DIST: begin
                if (r_den != '0) begin
                    n_state = S_DBUF;
                end else if (r_e < r_fill) begin
                    n_n = '0; n_den = '0; n_state = S_RHIT;
                end else begin
                    n_p = '0; n_state = S_UPD;
                end
            end
            S_DBUF: begin
                n_bpath      = r_buf_rd[SHARE_W +: PID_W];
                acc_raddr    = r_buf_rd[SHARE_W +: PATH_AW];
                div_start    = 1'b1;
                div_dividend = {r_buf_rd[SHARE_W-1:0], 16'b0};
                div_divisor  = r_den;
                n_state      = S_DDIV;
            end
            // Add the normalized share to the path's accumulator
            S_DDIV: begin
                if (div_done) begin
                    acc_we    = ({1'b0, r_bpath} < r_np);
                    acc_waddr = r_bpath[PATH_AW-1:0];
                    acc_wdata = acc_sum[ABN_W] ? '1 : acc_sum[ABN_W-1:0];
                    n_j       = r_j + 1'b1;
                    buf_raddr = n_j[BUF_AW-1:0];
                    if (n_j == r_n) begin
                        if (r_e < r_fill) begin
                            n_n = '0; n_den = '0; n_state = S_RHIT;
                        end else begin
                            n_p = '0; n_state = S_UPD;
                        end
                    end else begin
                        n_state = S_DBUF;
                    end
                end
            end
            S_UPD: begin
                acc_raddr = r_p[PATH_AW-1:0];
                n_state   = S_UMUL;
            end
            S_UMUL: begin
                acc_raddr = r_p[PATH_AW-1:0];
                mul_a     = r_abn_rd;
                mul_b     = r_eps;
                n_prod    = mul_p;
                n_old     = r_abn_rd;
                n_new     = r_acc_rd;
                n_state   = S_UCMP;
            end
            // Check convergence, move the new value in, clear the accumulator
            S_UCMP: begin
                n_cv      = r_cv && !unconv;
                abn_we    = 1'b1;
                abn_wdata = r_new;
                acc_we    = 1'b1;
                n_p       = r_p + 1'b1;
                n_state   = (n_p == r_np) ? S_UEND : S_UPD;
            end
            S_UEND: begin
                n_conv = r_cv;
                n_p    = '0;
                n_state = (r_cv || (r_iters >= r_maxit)) ? S_ERD : S_ITER;
            end
            S_ERD: n_state = S_EOUT;
            S_EOUT: begin
                if (out_acc) begin
                    if (r_p + 1'b1 == r_np) begin
                        n_fill  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_p     = r_p + 1'b1;
                        n_state = S_ERD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_eps    <= 16'd655;
            r_maxit  <= 16'd100;
            r_pcount <= 7'd32;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_EPSILON:  r_eps    <= i_cfg_data;
                    REG_MAX_ITER: r_maxit  <= i_cfg_data;
                    REG_PCOUNT:   r_pcount <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_e <= n_e; r_n <= n_n; r_j <= n_j; r_np <= n_np; r_p <= n_p;
        r_iters <= n_iters; r_conv <= n_conv; r_cv <= n_cv; r_den <= n_den;
        r_id <= n_id; r_hpath <= n_hpath; r_bpath <= n_bpath; r_hits <= n_hits;
        r_hw <= n_hw; r_eor <= n_eor; r_hmark <= n_hmark; r_prod <= n_prod;
        r_old <= n_old; r_new <= n_new;
    end

    // Memories: one write, registered read
    always_ff @(posedge i_clk) begin
        if (len_we)
            len_mem[i_in.path_id[PATH_AW-1:0]] <= i_in.path_length;
        r_len_rd <= len_mem[i_in.path_id[PATH_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (hit_we)
            hit_mem[r_fill[HIT_AW-1:0]] <= hit_wdata;
        r_hit_rd <= hit_mem[hit_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (abn_we)
            abn_mem[abn_waddr] <= abn_wdata;
        r_abn_rd <= abn_mem[abn_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (acc_we)
            acc_mem[acc_waddr] <= acc_wdata;
        r_acc_rd <= acc_mem[acc_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (buf_we)
            buf_mem[r_n[BUF_AW-1:0]] <= buf_wdata;
        r_buf_rd <= buf_mem[buf_raddr];
    end

endmodule
